// ----- design/bsc_pkg.sv -----
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int AdcW   = 20;
  localparam int WordW  = 64;
  localparam int OutW   = 32;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_TEMP    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PLOW    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PHIGH   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PNINE   = 2'd3;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic word_t asr(input word_t v, input int n);
    return word_t'($signed(v) >>> n);
  endfunction

  function automatic logic [OutW-1:0] sat_s32(input word_t v);
    logic [OutW-1:0] r;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [OutW-1:0] sat_u32(input word_t v);
    logic [OutW-1:0] r;
    if (v[63]) begin
      r = '0;
    end else if (v[62:32] != '0) begin
      r = '1;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/bsc_mul.sv -----
`timescale 1ns / 1ps
module bsc_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bsc_pkg::word_t  a,
  input  bsc_pkg::word_t  b,
  output logic            done,
  output bsc_pkg::word_t  p
);
  import bsc_pkg::*;

  word_t a_sh;
  word_t b_sh;
  word_t acc;
  logic [1:0] cnt;
  logic busy;
  logic [79:0] prod;

  assign prod = a_sh * b_sh[15:0];
  assign p = acc;

  // low 64 bits of the product, 16 multiplier bits a cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      a_sh <= a;
      b_sh <= b;
      acc <= '0;
      cnt <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      acc <= acc + prod[63:0];
      a_sh <= a_sh << 16;
      b_sh <= b_sh >> 16;
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- design/bsc_div.sv -----
`timescale 1ns / 1ps
module bsc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bsc_pkg::word_t  num,
  input  bsc_pkg::word_t  den,
  output logic            done,
  output bsc_pkg::word_t  quo
);
  import bsc_pkg::*;

  word_t rem;
  word_t q;
  word_t m;
  logic neg;
  logic [5:0] cnt;
  logic busy;
  logic [64:0] sh;
  logic [64:0] diff;
  logic ge;

  assign sh = {rem, q[63]};
  assign diff = sh - {1'b0, m};
  assign ge = sh >= {1'b0, m};
  assign quo = neg ? (word_t'(0) - q) : q;

  // signed, truncating toward zero, one quotient bit a cycle
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      q <= num[63] ? (word_t'(0) - num) : num;
      m <= den[63] ? (word_t'(0) - den) : den;
      neg <= num[63] ^ den[63];
      rem <= '0;
      cnt <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : sh[63:0];
      q <= {q[62:0], ge};
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ----- design/baro_sensor_compensation.sv -----
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                      | tuser
// s_axis  | in  | adc_temp[19:0], adc_press[39:20]        | -
// m_axis  | out | temp_centi[31:0], fine_temp[63:32],     | press_valid
//         |     | press_q8[95:64]                          |
// cfg     | in  | cfg_we, cfg_index, cfg_data (64 bits)    | -
// One word takes 14 multiplies on the shared 64x16 multiplier and one pass through the serial
// divider; when the divisor is 0 the divide and the last four multiplies are skipped.
// s_tready is high only while idle; the result waits in an output register.
// A stalled output holds the last step until taken. Reset is synchronous.
module baro_sensor_compensation (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // adc_temp, adc_press
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [95:0]          m_tdata,   // temp_centi, fine_temp, press_q8
  output logic                 m_tuser,   // press_valid
  input  logic                 cfg_we,
  input  logic [bsc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);
  import bsc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_T2   = 5'd3;
  localparam logic [4:0] S_T3   = 5'd4;
  localparam logic [4:0] S_P0   = 5'd5;
  localparam logic [4:0] S_P1   = 5'd6;
  localparam logic [4:0] S_P2   = 5'd7;
  localparam logic [4:0] S_P3   = 5'd8;
  localparam logic [4:0] S_P4   = 5'd9;
  localparam logic [4:0] S_P5   = 5'd10;
  localparam logic [4:0] S_P6   = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12;
  localparam logic [4:0] S_P7   = 5'd13;
  localparam logic [4:0] S_P8   = 5'd14;
  localparam logic [4:0] S_P9   = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;

  logic [4:0] state;
  logic issued;
  logic [AdcW-1:0] at;
  logic [AdcW-1:0] ap;
  word_t ra, rb, rc, rd, rp, tf, tc;
  logic pvalid;
  logic [OutW-1:0] held;
  logic [OutW-1:0] pq;

  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word_t mul_a, mul_b, mul_p, div_q, pt;
  logic is_mul, mul_start, mul_done, div_start, div_done;

  assign t1 = {48'd0, temp_coeffs[15:0]};
  assign t2 = sx16(temp_coeffs[31:16]);
  assign t3 = sx16(temp_coeffs[47:32]);
  assign p1 = {48'd0, press_coeffs_low[15:0]};
  assign p2 = sx16(press_coeffs_low[31:16]);
  assign p3 = sx16(press_coeffs_low[47:32]);
  assign p4 = sx16(press_coeffs_low[63:48]);
  assign p5 = sx16(press_coeffs_high[15:0]);
  assign p6 = sx16(press_coeffs_high[31:16]);
  assign p7 = sx16(press_coeffs_high[47:32]);
  assign p8 = sx16(press_coeffs_high[63:48]);
  assign p9 = sx16(press_coeff_nine);
  assign pt = word_t'(64'd1048576) - {44'd0, ap};

  always_comb begin
    mul_a = ra;
    mul_b = ra;
    is_mul = 1'b1;
    unique case (state)
      S_T0: begin
        mul_a = {47'd0, at[19:3]} - {47'd0, t1[15:0], 1'b0};
        mul_b = t2;
      end
      S_T1: begin
        mul_a = {48'd0, at[19:4]} - t1;
        mul_b = {48'd0, at[19:4]} - t1;
      end
      S_T2: begin mul_a = rb; mul_b = t3; end
      S_T3: begin mul_a = tf; mul_b = word_t'(64'd5); end
      S_P0: begin mul_a = ra; mul_b = ra; end
      S_P1: begin mul_a = rc; mul_b = p6; end
      S_P2: begin mul_a = ra; mul_b = p5; end
      S_P3: begin mul_a = rc; mul_b = p3; end
      S_P4: begin mul_a = ra; mul_b = p2; end
      S_P5: begin mul_a = (word_t'(1) << 47) + rd; mul_b = p1; end
      S_P6: begin mul_a = (pt << 31) - rb; mul_b = word_t'(64'd3125); end
      S_P7: begin mul_a = p9; mul_b = asr(rp, 13); end
      S_P8: begin mul_a = rc; mul_b = asr(rp, 13); end
      S_P9: begin mul_a = rp; mul_b = p8; end
      default: is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !issued;
  assign div_start = (state == S_DIV) && !issued;

  bsc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  bsc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(rc), .den(rd),
    .done(div_done), .quo(div_q)
  );

  assign s_tready = (state == S_IDLE);
  assign pq = pvalid ? sat_u32(rp) : held;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_coeffs_low <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP:  temp_coeffs <= cfg_data[47:0];
        CFG_PLOW:  press_coeffs_low <= cfg_data;
        CFG_PHIGH: press_coeffs_high <= cfg_data;
        CFG_PNINE: press_coeff_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
      m_tvalid <= 1'b0;
      held <= '0;
      pvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      if (mul_start || div_start) begin
        issued <= 1'b1;
      end else if (mul_done || div_done) begin
        issued <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            at <= s_tdata[19:0];
            ap <= s_tdata[39:20];
            state <= S_T0;
          end
        end
        S_T0: if (mul_done) begin ra <= asr(mul_p, 11); state <= S_T1; end
        S_T1: if (mul_done) begin rb <= asr(mul_p, 12); state <= S_T2; end
        S_T2: if (mul_done) begin tf <= ra + asr(mul_p, 14); state <= S_T3; end
        S_T3: if (mul_done) begin
          tc <= asr(mul_p + word_t'(64'd128), 8);
          ra <= tf - word_t'(64'd128000);
          state <= S_P0;
        end
        S_P0: if (mul_done) begin rc <= mul_p; state <= S_P1; end
        S_P1: if (mul_done) begin rb <= mul_p; state <= S_P2; end
        S_P2: if (mul_done) begin
          rb <= rb + (mul_p << 17) + (p4 << 35);
          state <= S_P3;
        end
        S_P3: if (mul_done) begin rd <= asr(mul_p, 8); state <= S_P4; end
        S_P4: if (mul_done) begin rd <= rd + (mul_p << 12); state <= S_P5; end
        S_P5: if (mul_done) begin
          rd <= asr(mul_p, 33);
          if (asr(mul_p, 33) == '0) begin
            pvalid <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_P6;
          end
        end
        S_P6: if (mul_done) begin rc <= mul_p; state <= S_DIV; end
        S_DIV: if (div_done) begin rp <= div_q; state <= S_P7; end
        S_P7: if (mul_done) begin rc <= mul_p; state <= S_P8; end
        S_P8: if (mul_done) begin rc <= asr(mul_p, 25); state <= S_P9; end
        S_P9: if (mul_done) begin rb <= asr(mul_p, 19); state <= S_FIN; end
        S_FIN: begin
          rp <= asr(rp + rc + rb, 8) + (p7 << 4);
          pvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {pq, sat_s32(tf), sat_s32(tc)};
            m_tuser <= pvalid;
            m_tvalid <= 1'b1;
            held <= pq;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/bsc_checker.sv -----
`timescale 1ns / 1ps
module bsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tuser
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("output word dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid after reset");
endmodule

bind baro_sensor_compensation bsc_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
